// ===== rtl/fwspa_pkg.sv =====
package fwspa_pkg;

	// Width of the CORDIC x, y and z words (Q2.30 for x and y, 2^32 per turn for z).
	localparam int CW = 34;
	// Index width of the arctangent table.
	localparam int ATAN_IDX_W = 5;
	// Number of entries in the arctangent table.
	localparam int ATAN_ENTRIES = 24;
	// CORDIC gain 0.60725... in Q2.30.
	localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

	localparam int IN_W = 64;
	localparam int OUT_W = 264;

	// Command word from the controller to the datapath.
	typedef struct packed {
		logic ld;
		logic rot;
		logic rnd;
		logic mul1;
		logic mul2;
		logic term;
		logic acc;
	} fwspa_cmd_t;

	// Arctangent of 2^-i in units of 2^32 per turn.
	function automatic logic signed [CW-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
		logic signed [CW-1:0] r;
		case (idx)
			5'd0: r = 34'sd536870912;
			5'd1: r = 34'sd316933406;
			5'd2: r = 34'sd167458907;
			5'd3: r = 34'sd85004756;
			5'd4: r = 34'sd42667331;
			5'd5: r = 34'sd21354465;
			5'd6: r = 34'sd10679838;
			5'd7: r = 34'sd5340245;
			5'd8: r = 34'sd2670163;
			5'd9: r = 34'sd1335087;
			5'd10: r = 34'sd667544;
			5'd11: r = 34'sd333772;
			5'd12: r = 34'sd166886;
			5'd13: r = 34'sd83443;
			5'd14: r = 34'sd41722;
			5'd15: r = 34'sd20861;
			5'd16: r = 34'sd10430;
			5'd17: r = 34'sd5215;
			5'd18: r = 34'sd2608;
			5'd19: r = 34'sd1304;
			5'd20: r = 34'sd652;
			5'd21: r = 34'sd326;
			5'd22: r = 34'sd163;
			5'd23: r = 34'sd81;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/flux_weighted_sky_position_accumulator.sv =====
// Flow: after its input transfer, a source passes through CORDIC_STEPS iterations of
// the two rotation lanes, then round, two multiply stages, term rounding and the
// saturating accumulate. A new source is taken only once the last one has left the
// accumulate step and the controller is idle again; an unread result stalls only the
// accumulate step.
// Reset: arst_n clears the four sums, the saturation flag and the controller at once.
module flux_weighted_sky_position_accumulator #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// Fields from bit 0: right_ascension[15:0], declination[31:16], source_flux[63:32].
	input  logic [63:0]  s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// Fields from bit 0: sum_x[63:0], sum_y[127:64], sum_z[191:128],
	// sum_weight[255:192], saturated[256], zero padding [263:257].
	output logic [263:0] m_tdata
);

	localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	// The controller sequences one source at a time through the datapath. The
	// input transfer starts the rotation of both angles in parallel lanes.
	fwspa_pkg::fwspa_cmd_t cmd;
	logic [SW-1:0]         step_idx;

	fwspa_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.step_idx (step_idx)
	);

	// The running sums sit in the datapath and also serve as the output
	// register, so a new source is taken while the last result still waits.
	fwspa_dp #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.step_idx (step_idx),
		.s_tdata  (s_tdata),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== rtl/fwspa_ctrl.sv =====
module fwspa_ctrl #(
	parameter int CORDIC_STEPS = 16,
	localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output fwspa_pkg::fwspa_cmd_t  cmd,
	output logic [SW-1:0]          step_idx
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROT,
		S_RND,
		S_MUL1,
		S_MUL2,
		S_TERM,
		S_ACC
	} state_t;

	state_t        state_q;
	logic [SW-1:0] cnt_q;
	logic          out_valid_q;
	logic          acc_fire;

	// The accumulators double as the output register, so they are only
	// updated once the previous result has been taken.
	assign acc_fire = (state_q == S_ACC) && (!out_valid_q || m_tready);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign step_idx = cnt_q;

	always_comb begin
		cmd      = '0;
		cmd.ld   = (state_q == S_IDLE) && s_tvalid;
		cmd.rot  = (state_q == S_ROT);
		cmd.rnd  = (state_q == S_RND);
		cmd.mul1 = (state_q == S_MUL1);
		cmd.mul2 = (state_q == S_MUL2);
		cmd.term = (state_q == S_TERM);
		cmd.acc  = acc_fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (s_tvalid) begin
						state_q <= S_ROT;
					end
				end
				S_ROT: begin
					if (cnt_q == SW'(CORDIC_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_RND;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_RND:  state_q <= S_MUL1;
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_TERM;
				S_TERM: state_q <= S_ACC;
				S_ACC: begin
					if (acc_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/fwspa_dp.sv =====
module fwspa_dp #(
	parameter int CORDIC_STEPS = 16,
	localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  fwspa_pkg::fwspa_cmd_t          cmd,
	input  logic [SW-1:0]                  step_idx,
	input  logic [fwspa_pkg::IN_W-1:0]     s_tdata,
	output logic [fwspa_pkg::OUT_W-1:0]    m_tdata
);

	localparam int CW = fwspa_pkg::CW;

	// Round half up from Q2.30 (or a Q1.15 product) to Q1.15, then saturate.
	function automatic logic signed [15:0] round_q15(input logic signed [CW:0] v);
		logic signed [CW+1:0] t;
		logic signed [CW+1:0] r;
		logic signed [15:0]   q;
		t = {v[CW], v} + (CW+2)'(16384);
		r = t >>> 15;
		if (r > (CW+2)'(32767)) begin
			q = 16'sh7fff;
		end else if (r < -(CW+2)'(32768)) begin
			q = 16'sh8000;
		end else begin
			q = r[15:0];
		end
		return q;
	endfunction

	// Saturating 64-bit add; ovf reports a clip.
	function automatic logic [64:0] sat_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		logic               ovf;
		logic [63:0]        r;
		s   = {a[63], a} + {b[63], b};
		ovf = s[64] ^ s[63];
		if (ovf) begin
			r = s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
		end else begin
			r = s[63:0];
		end
		return {ovf, r};
	endfunction

	// Input item.
	logic signed [31:0] flux_q;

	// Two CORDIC lanes: lane 0 is right ascension, lane 1 is declination.
	logic signed [CW-1:0] x_q [2];
	logic signed [CW-1:0] y_q [2];
	logic signed [CW-1:0] z_q [2];
	logic                 flip_q [2];

	logic signed [CW-1:0] z_init [2];
	logic                 flip_init [2];
	logic signed [CW-1:0] x_nxt [2];
	logic signed [CW-1:0] y_nxt [2];
	logic signed [CW-1:0] z_nxt [2];

	// Post-processing pipeline.
	logic signed [15:0] cra_s1, sra_s1, cdec_s1, sdec_s1;
	logic signed [31:0] px_s2, py_s2;
	logic signed [15:0] sdec_s2;
	logic signed [47:0] wx_s3, wy_s3, wz_s3;
	logic signed [33:0] tx_s4, ty_s4, tz_s4;

	logic signed [63:0] acc_x_q, acc_y_q, acc_z_q, acc_w_q;
	logic               clip_q;

	logic signed [15:0] ux, uy;
	logic [64:0]        nx, ny, nz, nw;

	always_comb begin
		logic signed [15:0] a;
		logic signed [16:0] t;
		logic signed [CW-1:0] dx, dy, at;
		for (int l = 0; l < 2; l++) begin
			a = (l == 0) ? s_tdata[15:0] : s_tdata[31:16];
			t = {a[15], a};
			flip_init[l] = 1'b0;
			if (t > 17'sd16384) begin
				t = t - 17'sd32768;
				flip_init[l] = 1'b1;
			end else if (t < -17'sd16384) begin
				t = t + 17'sd32768;
				flip_init[l] = 1'b1;
			end
			z_init[l] = {t[16], t, 16'b0};

			dx = x_q[l];
			dy = y_q[l];
			dx = y_q[l] >>> step_idx;
			dy = x_q[l] >>> step_idx;
			at = fwspa_pkg::atan_turn(fwspa_pkg::ATAN_IDX_W'(step_idx));
			if (!z_q[l][CW-1]) begin
				x_nxt[l] = x_q[l] - dx;
				y_nxt[l] = y_q[l] + dy;
				z_nxt[l] = z_q[l] - at;
			end else begin
				x_nxt[l] = x_q[l] + dx;
				y_nxt[l] = y_q[l] - dy;
				z_nxt[l] = z_q[l] + at;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld) begin
			flux_q <= s_tdata[63:32];
		end
		for (int l = 0; l < 2; l++) begin
			if (cmd.ld) begin
				x_q[l]    <= fwspa_pkg::CORDIC_GAIN_Q30;
				y_q[l]    <= '0;
				z_q[l]    <= z_init[l];
				flip_q[l] <= flip_init[l];
			end else if (cmd.rot) begin
				x_q[l] <= x_nxt[l];
				y_q[l] <= y_nxt[l];
				z_q[l] <= z_nxt[l];
			end
		end
	end

	assign ux = round_q15((CW+1)'(px_s2));
	assign uy = round_q15((CW+1)'(py_s2));

	always_ff @(posedge clk) begin
		if (cmd.rnd) begin
			cra_s1  <= round_q15(flip_q[0] ? -{x_q[0][CW-1], x_q[0]} : {x_q[0][CW-1], x_q[0]});
			sra_s1  <= round_q15(flip_q[0] ? -{y_q[0][CW-1], y_q[0]} : {y_q[0][CW-1], y_q[0]});
			cdec_s1 <= round_q15(flip_q[1] ? -{x_q[1][CW-1], x_q[1]} : {x_q[1][CW-1], x_q[1]});
			sdec_s1 <= round_q15(flip_q[1] ? -{y_q[1][CW-1], y_q[1]} : {y_q[1][CW-1], y_q[1]});
		end
		if (cmd.mul1) begin
			px_s2   <= cra_s1 * cdec_s1;
			py_s2   <= sra_s1 * cdec_s1;
			sdec_s2 <= sdec_s1;
		end
		if (cmd.mul2) begin
			wx_s3 <= ux * flux_q;
			wy_s3 <= uy * flux_q;
			wz_s3 <= sdec_s2 * flux_q;
		end
		if (cmd.term) begin
			tx_s4 <= 34'((49'(wx_s3) + 49'sd16384) >>> 15);
			ty_s4 <= 34'((49'(wy_s3) + 49'sd16384) >>> 15);
			tz_s4 <= 34'((49'(wz_s3) + 49'sd16384) >>> 15);
		end
	end

	assign nx = sat_add(acc_x_q, 64'(tx_s4));
	assign ny = sat_add(acc_y_q, 64'(ty_s4));
	assign nz = sat_add(acc_z_q, 64'(tz_s4));
	assign nw = sat_add(acc_w_q, 64'(flux_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
			acc_z_q <= '0;
			acc_w_q <= '0;
			clip_q  <= 1'b0;
		end else if (cmd.acc) begin
			acc_x_q <= nx[63:0];
			acc_y_q <= ny[63:0];
			acc_z_q <= nz[63:0];
			acc_w_q <= nw[63:0];
			clip_q  <= clip_q | nx[64] | ny[64] | nz[64] | nw[64];
		end
	end

	assign m_tdata = {7'b0, clip_q, acc_w_q, acc_z_q, acc_y_q, acc_x_q};

endmodule

// ===== rtl/fwspa_chk.sv =====
module fwspa_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [63:0]  s_tdata,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [263:0] m_tdata
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// The saturation flag is sticky.
	a_sat_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_tdata[256] |=> m_tdata[256])
		else $error("saturation flag cleared");

	// One source at a time: an input transfer closes the input side.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while busy");

	// The sums only move together with a new result.
	a_sum_update: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |=> m_tvalid || $stable(m_tdata))
		else $error("sums changed without a result");

endmodule

bind flux_weighted_sky_position_accumulator fwspa_chk u_fwspa_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
